### hdl/assert_macros.svh
// Assertion helpers included by ffha_core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/ffha_pkg.sv
package ffha_pkg;

  // Pointer width: covers the largest header pointer plus a block size plus two.
  localparam int unsigned PTR_W = 18;

  localparam logic [15:0] OWNER_FREE    = 16'hFFFF;
  localparam logic [15:0] OWNER_TAKEN   = 16'h0000;
  localparam logic [15:0] HEAP_BASE_RST = 16'h1000;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ZERO_SIZE = 2'd1,
    ST_OVER_FREE = 2'd2,
    ST_NO_FIT    = 2'd3
  } status_e;

  typedef struct packed {
    logic        kind;
    logic [15:0] request_size;
    logic [15:0] block_address;
  } ffha_req_t;

  typedef struct packed {
    logic [15:0] data_address;
    status_e     status;
  } ffha_res_t;

endpackage

### hdl/ffha_core.sv
module ffha_core import ffha_pkg::*; #(
  parameter int unsigned HEAP_WORDS = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] heap_base_i,
  input  logic        start_i,
  input  ffha_req_t   req_i,
  output logic        ready_o,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output ffha_res_t   res_o
);

`include "assert_macros.svh"

  localparam int unsigned AW = $clog2(HEAP_WORDS);
  localparam logic [PTR_W-1:0] HW_P    = PTR_W'(HEAP_WORDS);
  localparam logic [PTR_W-1:0] HW_M2_P = PTR_W'(HEAP_WORDS - 2);

  typedef enum logic [3:0] {
    S_INIT0, S_INIT1, S_IDLE, S_LOOP, S_OWN, S_SIZE, S_GRANT,
    S_SPLIT_OWN, S_SPLIT_SIZE, S_SPLIT_HDR, S_FILL_INIT, S_FILL, S_FIN, S_RESP
  } state_e;

  state_e      state_q, state_d;
  logic [15:0] fc_q, fc_d;
  ffha_res_t   res_q, res_d;

  logic             kind_q, kind_d;
  logic [15:0]      req_q, req_d;
  logic [15:0]      off_q, off_d;
  logic [PTR_W-1:0] p_q, p_d;
  logic             owner_free_q, owner_free_d;
  logic [15:0]      size_q, size_d;
  logic [PTR_W-1:0] end_q, end_d;
  logic [15:0]      left_q, left_d;
  logic [15:0]      granted_q, granted_d;
  logic [PTR_W-1:0] wptr_q, wptr_d;

  // Heap storage, single port, registered read.
  logic [15:0]      mem [HEAP_WORDS];
  logic [15:0]      rd_q;
  logic             mem_we;
  logic [PTR_W-1:0] mem_addr;
  logic [15:0]      mem_wdata;

  // Shared pointer adder.
  logic [PTR_W-1:0] add_a, add_b, add_sum;
  logic [1:0]       add_c;

  logic [15:0] off_new;
  logic [16:0] fc_add;
  logic [15:0] left_new;
  logic        blk_fit, walk_stop;

  assign add_sum  = add_a + add_b + PTR_W'(add_c);
  assign off_new  = req_i.block_address - heap_base_i;
  assign fc_add   = {1'b0, fc_q} + {1'b0, rd_q};
  assign left_new = size_q - req_q;

  // Block checks evaluated when the size word arrives.
  assign blk_fit   = owner_free_q && (rd_q >= req_q) && (add_sum <= HW_P);
  assign walk_stop = (add_sum >= {2'b00, off_q}) || (add_sum > HW_M2_P);

  assign ready_o     = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_RESP);
  assign res_o       = res_q;

  // Sequencer: adder operands, memory access and next state.
  always_comb begin
    state_d      = state_q;
    fc_d         = fc_q;
    res_d        = res_q;
    kind_d       = kind_q;
    req_d        = req_q;
    off_d        = off_q;
    p_d          = p_q;
    owner_free_d = owner_free_q;
    size_d       = size_q;
    end_d        = end_q;
    left_d       = left_q;
    granted_d    = granted_q;
    wptr_d       = wptr_q;
    add_a        = p_q;
    add_b        = '0;
    add_c        = 2'd0;
    mem_we       = 1'b0;
    mem_addr     = p_q;
    mem_wdata    = OWNER_TAKEN;
    case (state_q)
      S_INIT0: begin
        mem_we    = 1'b1;
        mem_addr  = '0;
        mem_wdata = OWNER_FREE;
        state_d   = S_INIT1;
      end
      S_INIT1: begin
        mem_we    = 1'b1;
        mem_addr  = PTR_W'(1);
        mem_wdata = 16'(HEAP_WORDS - 2);
        state_d   = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          kind_d = req_i.kind;
          req_d  = req_i.request_size;
          off_d  = off_new;
          p_d    = '0;
          if (req_i.kind == KIND_ALLOC) begin
            if (req_i.request_size == 16'd0) begin
              res_d   = '{data_address: 16'd0, status: ST_ZERO_SIZE};
              state_d = S_RESP;
            end else if ({1'b0, req_i.request_size} + 17'd2 > {1'b0, fc_q}) begin
              res_d   = '{data_address: 16'd0, status: ST_OVER_FREE};
              state_d = S_RESP;
            end else begin
              state_d = S_LOOP;
            end
          end else if ({1'b0, off_new} <= 17'(HEAP_WORDS)) begin
            state_d = S_LOOP;
          end
        end
      end
      // Issue owner read, or on an allocation give up when the chain is exhausted.
      S_LOOP: begin
        if (kind_q == KIND_ALLOC && p_q > HW_M2_P) begin
          res_d   = '{data_address: 16'd0, status: ST_NO_FIT};
          state_d = S_RESP;
        end else begin
          state_d = S_OWN;
        end
      end
      // Owner word arrives; issue size read.
      S_OWN: begin
        add_c        = 2'd1;
        mem_addr     = add_sum;
        owner_free_d = (rd_q == OWNER_FREE);
        state_d      = S_SIZE;
      end
      // Size word arrives; next header = p + size + 2.
      S_SIZE: begin
        add_b  = {2'b00, rd_q};
        add_c  = 2'd2;
        size_d = rd_q;
        if (kind_q == KIND_ALLOC) begin
          if (blk_fit) begin
            mem_we    = 1'b1;
            mem_wdata = OWNER_TAKEN;
            state_d   = S_GRANT;
          end else begin
            p_d     = add_sum;
            state_d = S_LOOP;
          end
        end else if (walk_stop) begin
          mem_we    = 1'b1;
          mem_wdata = OWNER_FREE;
          fc_d      = fc_add[16] ? 16'hFFFF : fc_add[15:0];
          state_d   = S_IDLE;
        end else begin
          p_d     = add_sum;
          state_d = S_LOOP;
        end
      end
      // End of granted data = p + 2 + req; decide on a split.
      S_GRANT: begin
        add_b  = {2'b00, req_q};
        add_c  = 2'd2;
        end_d  = add_sum;
        left_d = left_new;
        if (left_new >= 16'd3) begin
          granted_d = req_q;
          state_d   = S_SPLIT_OWN;
        end else begin
          granted_d = size_q;
          state_d   = S_FILL_INIT;
        end
      end
      S_SPLIT_OWN: begin
        mem_we    = 1'b1;
        mem_addr  = end_q;
        mem_wdata = OWNER_FREE;
        state_d   = S_SPLIT_SIZE;
      end
      S_SPLIT_SIZE: begin
        add_a     = end_q;
        add_c     = 2'd1;
        mem_we    = 1'b1;
        mem_addr  = add_sum;
        mem_wdata = left_q - 16'd2;
        state_d   = S_SPLIT_HDR;
      end
      S_SPLIT_HDR: begin
        add_c     = 2'd1;
        mem_we    = 1'b1;
        mem_addr  = add_sum;
        mem_wdata = req_q;
        state_d   = S_FILL_INIT;
      end
      S_FILL_INIT: begin
        add_c   = 2'd2;
        wptr_d  = add_sum;
        state_d = S_FILL;
      end
      // Zero-fill one data word per cycle.
      S_FILL: begin
        add_a = wptr_q;
        add_c = 2'd1;
        if (wptr_q == end_q) begin
          state_d = S_FIN;
        end else begin
          mem_we    = 1'b1;
          mem_addr  = wptr_q;
          mem_wdata = 16'd0;
          wptr_d    = add_sum;
        end
      end
      S_FIN: begin
        add_b   = {2'b00, heap_base_i};
        add_c   = 2'd2;
        fc_d    = (granted_q >= fc_q) ? 16'd0 : fc_q - granted_q;
        res_d   = '{data_address: add_sum[15:0], status: ST_OK};
        state_d = S_RESP;
      end
      S_RESP: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state and registered result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT0;
      fc_q    <= 16'(HEAP_WORDS);
      res_q   <= '{data_address: 16'd0, status: ST_OK};
    end else begin
      state_q <= state_d;
      fc_q    <= fc_d;
      res_q   <= res_d;
    end
  end

  // Walk datapath.
  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    req_q        <= req_d;
    off_q        <= off_d;
    p_q          <= p_d;
    owner_free_q <= owner_free_d;
    size_q       <= size_d;
    end_q        <= end_d;
    left_q       <= left_d;
    granted_q    <= granted_d;
    wptr_q       <= wptr_d;
  end

  // Heap memory.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr[AW-1:0]] <= mem_wdata;
    end
    rd_q <= mem[mem_addr[AW-1:0]];
  end

  `ASSERT_IMPLIES(a_start_when_ready, clk_i, rst_ni, start_i, ready_o,
                  "request started while walk busy")
  `ASSERT_IMPLIES(a_write_in_heap, clk_i, rst_ni, mem_we, mem_addr < HW_P,
                  "heap write outside heap")
  `ASSERT_IMPLIES(a_fill_bound, clk_i, rst_ni, state_q == S_FILL, wptr_q <= end_q,
                  "zero fill ran past block end")
  `ASSERT_NEXT(a_alloc_no_gain, clk_i, rst_ni, state_q == S_FIN, fc_q <= $past(fc_q),
               "free count grew on allocation")
  `ASSERT_IMPLIES(a_resp_alloc_only, clk_i, rst_ni, state_q == S_RESP,
                  kind_q == KIND_ALLOC, "result produced for a free request")

endmodule

### hdl/first_fit_heap_allocator.sv
// Channel | Direction | Handshake               | Payload
// in      | input     | in_valid_i / in_stall_o | kind_i, request_size_i, block_address_i
// out     | output    | out_valid_o / out_stall_i | data_address_o, status_o
// cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_heap_base_i
//
// One request at a time; the heap walk does at most one memory access per cycle.
// After an accepted beat in_stall_o stays high while the walk visits each block header
// and, on an allocate fit, claims the block, splits it if large enough, zero-fills
// request_size words and forms the result; a free gives no result beat.
// After reset, in_stall_o stays high while the first header is written.
// A result beat waits in the output register; only a full, stalled register holds the walk.
module first_fit_heap_allocator import ffha_pkg::*; #(
  parameter int unsigned HEAP_WORDS = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_heap_base_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [15:0] request_size_i,
  input  logic [15:0] block_address_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] data_address_o,
  output logic [1:0]  status_o
);

  logic [15:0] heap_base_q;
  logic        core_ready, core_res_valid, core_res_ready, start;
  ffha_req_t   core_req;
  ffha_res_t   core_res;
  logic        out_valid_q;
  ffha_res_t   out_res_q;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = !core_ready;
  assign start       = in_valid_i && core_ready;
  assign core_req    = '{kind: kind_i, request_size: request_size_i,
                         block_address: block_address_i};

  // Result beat moves into the output register when it is empty or draining.
  assign core_res_ready = !out_valid_q || !out_stall_i;

  assign out_valid_o    = out_valid_q;
  assign data_address_o = out_res_q.data_address;
  assign status_o       = out_res_q.status;

  // Heap base register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_base_q <= HEAP_BASE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      heap_base_q <= cfg_heap_base_i;
    end
  end

  // Output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (core_res_ready) begin
      out_valid_q <= core_res_valid;
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (core_res_ready && core_res_valid) begin
      out_res_q <= core_res;
    end
  end

  ffha_core #(
    .HEAP_WORDS(HEAP_WORDS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .heap_base_i(heap_base_q),
    .start_i    (start),
    .req_i      (core_req),
    .ready_o    (core_ready),
    .res_valid_o(core_res_valid),
    .res_ready_i(core_res_ready),
    .res_o      (core_res)
  );

endmodule
